// ===== rtl/core/iirdf_pkg.sv =====
// Shared constants, types and controller states for the direct-form IIR filter.
// No dependencies; every other file of the filter imports it.
`timescale 1ns / 1ps

package iirdf_pkg;

    localparam int DATA_W       = 16;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int ACC_W        = 48;
    localparam int CFG_IDX_W    = 4;
    localparam int CFG_NUM_REGS = 8;
    localparam int REG_FB_BASE  = 4;
    localparam int NUM_BANK     = 4;
    localparam int TAPS_DEFAULT = 4;
    localparam int DIV_STEPS    = 16;
    localparam int STEP_W       = $clog2(DIV_STEPS);
    localparam int REM_W        = 32;

    localparam logic [DATA_W-1:0] COEF_ONE = 16'h1000;
    localparam logic [DATA_W-1:0] Y_MAX    = 16'h7FFF;
    localparam logic [DATA_W-1:0] Y_MIN    = 16'h8000;

    typedef logic signed [DATA_W-1:0] t_coef;
    typedef t_coef [NUM_BANK-1:0] t_coef_bank;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAC,
        S_ACC,
        S_DIVSET,
        S_DIV,
        S_RESULT,
        S_OUT,
        S_UPD,
        S_UEND
    } t_state;

    typedef struct packed {
        logic load;
        logic mac;
        logic div_set;
        logic div_step;
        logic result;
        logic publish;
        logic upd;
        logic shift;
    } t_dp_cmd;

    typedef struct packed {
        logic k_last;
        logic div_skip;
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/core/iir_filter_direct_form_top.sv =====
// IIR filter, direct feedforward and transposed feedback: one result per input transaction.
// The MAC runs on a shared multiplier, then a 16-step divider; a zero divisor or overflow skips
// the divider. A new transaction is accepted only in idle, after the result is published and
// the feedback state update is done, so a stalled output also holds off the next input.
// Reset: synchronous active low; clears history, feedback states and coefficients to unity.
`timescale 1ns / 1ps

module iir_filter_direct_form_top #(
    parameter int TAPS = iirdf_pkg::TAPS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [iirdf_pkg::DATA_W-1:0]    s_axis_tdata,   // [15:0] sample
    input  logic [0:0]                      s_axis_tuser,   // [0] restart
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [iirdf_pkg::DATA_W-1:0]    m_axis_tdata,   // [15:0] filtered
    output logic [1:0]                      m_axis_tuser,   // [0] saturated, [1] divide_error
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [iirdf_pkg::DATA_W-1:0]    i_cfg_data
);
    import iirdf_pkg::*;

    t_coef_bank ff;
    t_coef_bank fb;
    t_dp_cmd    cmd;
    t_dp_sts    sts;
    logic       sat;
    logic       derr;

    iirdf_cfg_regs #(
        .TAPS (TAPS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ff        (ff),
        .o_fb        (fb)
    );

    iirdf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    iirdf_datapath #(
        .TAPS (TAPS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (s_axis_tdata),
        .i_restart (s_axis_tuser[0]),
        .i_ff      (ff),
        .i_fb      (fb),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_m_ready (m_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_y       (m_axis_tdata),
        .o_sat     (sat),
        .o_derr    (derr)
    );

    assign m_axis_tuser = {derr, sat};

endmodule

// ===== rtl/core/iirdf_cfg_regs.sv =====
// Coefficient register file: feedforward and feedback banks, written over the config channel.
// Depends on iirdf_pkg.
`timescale 1ns / 1ps

module iirdf_cfg_regs #(
    parameter int TAPS = iirdf_pkg::TAPS_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [iirdf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [iirdf_pkg::DATA_W-1:0]       i_cfg_data,
    output iirdf_pkg::t_coef_bank              o_ff,
    output iirdf_pkg::t_coef_bank              o_fb
);
    import iirdf_pkg::*;

    localparam int NREG = (TAPS < NUM_BANK) ? TAPS : NUM_BANK;
    localparam t_coef_bank BANK_RESET = {{((NUM_BANK - 1) * DATA_W){1'b0}}, COEF_ONE};

    t_coef_bank r_ff;
    t_coef_bank r_fb;
    logic       wr_en;
    logic [1:0] slot;

    assign slot        = i_cfg_index[1:0];
    assign o_cfg_ready = 1'b1;
    assign wr_en       = i_cfg_valid
                         && ({1'b0, i_cfg_index} < (CFG_IDX_W + 1)'(CFG_NUM_REGS))
                         && ({1'b0, slot} < 3'(NREG));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff <= BANK_RESET;
            r_fb <= BANK_RESET;
        end else if (wr_en) begin
            if ({1'b0, i_cfg_index} >= (CFG_IDX_W + 1)'(REG_FB_BASE)) begin
                r_fb[slot] <= i_cfg_data;
            end else begin
                r_ff[slot] <= i_cfg_data;
            end
        end
    end

    assign o_ff = r_ff;
    assign o_fb = r_fb;

endmodule

// ===== rtl/core/iirdf_ctrl.sv =====
// Sequencer for one sample: MAC, divide, result, output, feedback state update.
// Depends on iirdf_pkg; drives iirdf_datapath through command and status structs.
`timescale 1ns / 1ps

module iirdf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  iirdf_pkg::t_dp_sts i_sts,
    output iirdf_pkg::t_dp_cmd o_cmd
);
    import iirdf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MAC;
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_state = S_DIVSET;
            end
            S_DIVSET: begin
                o_cmd.div_set = 1'b1;
                n_state       = i_sts.div_skip ? S_RESULT : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                o_cmd.result = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                if (i_sts.k_last) begin
                    n_state = S_UEND;
                end
            end
            S_UEND: begin
                o_cmd.shift = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == S_MAC))
        else $error("accepted transaction did not start the MAC phase");

    a_publish_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> i_sts.out_free)
        else $error("result published over an untaken output");

    a_div_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !i_sts.div_last) |=> (r_state == S_DIV))
        else $error("divider left before its last step");
`endif

endmodule

// ===== rtl/core/iirdf_datapath.sv =====
// Datapath: shared 16x16 multiplier, 48-bit accumulator, radix-2 divider,
// saturation, input history, feedback states and the output register. Depends on iirdf_pkg.
`timescale 1ns / 1ps

module iirdf_datapath #(
    parameter int TAPS = iirdf_pkg::TAPS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [iirdf_pkg::DATA_W-1:0]  i_sample,
    input  logic                          i_restart,
    input  iirdf_pkg::t_coef_bank         i_ff,
    input  iirdf_pkg::t_coef_bank         i_fb,
    input  iirdf_pkg::t_dp_cmd            i_cmd,
    output iirdf_pkg::t_dp_sts            o_sts,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic [iirdf_pkg::DATA_W-1:0]  o_y,
    output logic                          o_sat,
    output logic                          o_derr
);
    import iirdf_pkg::*;

    localparam int KW = (TAPS > 2) ? $clog2(TAPS) : 1;
    localparam int SW = (TAPS > 2) ? $clog2(TAPS - 1) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(TAPS - 1);

    logic signed [DATA_W-1:0] r_hist  [0:TAPS-2];
    logic signed [ACC_W-1:0]  r_fbst  [0:TAPS-2];
    logic signed [DATA_W-1:0] r_x;
    logic signed [ACC_W-1:0]  r_acc;
    logic [KW-1:0]            r_k;
    logic [KW-1:0]            r_pk;
    logic                     r_pv;
    logic                     r_pupd;
    logic signed [PROD_W-1:0] r_prod;
    logic [REM_W-1:0]         r_rem;
    logic [REM_W-1:0]         r_dsh;
    logic [DATA_W-1:0]        r_q;
    logic [STEP_W-1:0]        r_step;
    logic                     r_neg;
    logic                     r_zero;
    logic                     r_ovf;
    logic [DATA_W-1:0]        r_y;
    logic                     r_sat;
    logic                     r_derr;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_y;
    logic                     r_out_sat;
    logic                     r_out_derr;

    logic signed [DATA_W-1:0] ff_k;
    logic signed [DATA_W-1:0] fb_k;
    logic signed [DATA_W-1:0] x_k;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic [KW-1:0]            k_m1;
    logic [KW-1:0]            pk_m1;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  st_next;
    logic [ACC_W-1:0]         a_mag;
    logic [DATA_W:0]          d_ext;
    logic [DATA_W:0]          d_mag;
    logic                     d_zero;
    logic                     q_ovf;
    logic [REM_W:0]           diff;
    logic                     over_pos;
    logic                     over_neg;
    logic [DATA_W-1:0]        q_neg;

    always_comb begin
        ff_k = '0;
        fb_k = '0;
        for (int i = 0; i < NUM_BANK; i++) begin
            if (i < TAPS && r_k == KW'(i)) begin
                ff_k = $signed(i_ff[i]);
                fb_k = $signed(i_fb[i]);
            end
        end
    end

    assign k_m1  = r_k - KW'(1);
    assign pk_m1 = r_pk - KW'(1);
    assign x_k   = (r_k == '0) ? r_x : r_hist[k_m1[SW-1:0]];
    assign mul_a = i_cmd.upd ? fb_k : ff_k;
    assign mul_b = i_cmd.upd ? $signed(r_y) : x_k;

    assign prod_ext = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign st_next  = (r_pk == K_LAST) ? '0 : r_fbst[r_pk[SW-1:0]];

    assign a_mag  = r_acc[ACC_W-1] ? (~r_acc + ACC_W'(1)) : r_acc;
    assign d_ext  = {i_fb[0][DATA_W-1], i_fb[0]};
    assign d_mag  = d_ext[DATA_W] ? (~d_ext + (DATA_W + 1)'(1)) : d_ext;
    assign d_zero = (i_fb[0] == '0);
    assign q_ovf  = a_mag >= {{(ACC_W - DATA_W - 1 - DATA_W){1'b0}}, d_mag, {DATA_W{1'b0}}};
    assign diff   = {1'b0, r_rem} - {1'b0, r_dsh};

    assign over_pos = !r_neg && r_q[DATA_W-1];
    assign over_neg = r_neg && r_q[DATA_W-1] && (r_q[DATA_W-2:0] != '0);
    assign q_neg    = ~r_q + DATA_W'(1);

    assign o_sts.k_last   = (r_k == K_LAST);
    assign o_sts.div_skip = d_zero || q_ovf;
    assign o_sts.div_last = (r_step == STEP_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < TAPS - 1; i++) begin
                r_hist[i] <= '0;
                r_fbst[i] <= '0;
            end
        end else begin
            r_pv <= i_cmd.mac || i_cmd.upd;
            if (i_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.load && i_restart) begin
                for (int i = 0; i < TAPS - 1; i++) begin
                    r_hist[i] <= '0;
                    r_fbst[i] <= '0;
                end
            end
            if (r_pv && r_pupd) begin
                r_fbst[pk_m1[SW-1:0]] <= st_next - prod_ext;
            end
            if (i_cmd.shift) begin
                for (int i = TAPS - 2; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= r_x;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x   <= i_sample;
            r_acc <= i_restart ? '0 : r_fbst[0];
            r_k   <= '0;
        end else if (i_cmd.mac || i_cmd.upd) begin
            r_k <= r_k + KW'(1);
        end else if (i_cmd.result) begin
            r_k <= KW'(1);
        end
        if (i_cmd.mac || i_cmd.upd) begin
            r_prod <= mul_a * mul_b;
            r_pk   <= r_k;
            r_pupd <= i_cmd.upd;
        end
        if (r_pv && !r_pupd) begin
            r_acc <= r_acc + prod_ext;
        end
        if (i_cmd.div_set) begin
            r_rem  <= a_mag[REM_W-1:0];
            r_dsh  <= {d_mag, {(REM_W - DATA_W - 1){1'b0}}};
            r_q    <= '0;
            r_step <= '0;
            r_neg  <= r_acc[ACC_W-1] ^ i_fb[0][DATA_W-1];
            r_zero <= d_zero;
            r_ovf  <= q_ovf;
        end
        if (i_cmd.div_step) begin
            if (!diff[REM_W]) begin
                r_rem <= diff[REM_W-1:0];
            end
            r_q    <= {r_q[DATA_W-2:0], !diff[REM_W]};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.result) begin
            priority if (r_zero) begin
                r_y    <= '0;
                r_sat  <= 1'b0;
                r_derr <= 1'b1;
            end else if (r_ovf || over_pos || over_neg) begin
                r_y    <= r_neg ? Y_MIN : Y_MAX;
                r_sat  <= 1'b1;
                r_derr <= 1'b0;
            end else begin
                r_y    <= r_neg ? q_neg : r_q;
                r_sat  <= 1'b0;
                r_derr <= 1'b0;
            end
        end
        if (i_cmd.publish) begin
            r_out_y    <= r_y;
            r_out_sat  <= r_sat;
            r_out_derr <= r_derr;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_y       = r_out_y;
    assign o_sat     = r_out_sat;
    assign o_derr    = r_out_derr;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ({1'b0, r_rem} < {r_dsh, 1'b0}))
        else $error("divider remainder out of range");

    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_derr) |-> (r_out_y == '0 && !r_out_sat))
        else $error("divide error with nonzero output or saturation");

    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |-> (r_out_y == Y_MAX || r_out_y == Y_MIN))
        else $error("saturated output not at a rail");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for iir_filter_direct_form_top: streams samples through the filter
// and compares every output against a bit-exact model kept in the bench or a scripted value.
// Depends on iirdf_pkg and the filter RTL only.
`timescale 1ns / 1ps

module tb;
    import iirdf_pkg::*;

    localparam int NTAPS           = TAPS_DEFAULT;
    localparam int NUM_PHASES      = 11;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PAUSE_PHASE     = 3;
    localparam int HOLD_AT         = 300;
    localparam int HOLD_CYCLES     = 250;
    localparam int TAIL_CYCLES     = 64;
    localparam int MAX_PRINTS      = 50;

    localparam logic [CFG_IDX_W-1:0] REG_FF0       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF1       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF2       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF3       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FB0       = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB1       = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB2       = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FB3       = 4'd7;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 4'd15;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} t_row_kind;
    typedef enum int {MODE_WILD, MODE_GENTLE, MODE_EDGE, MODE_NODIV, MODE_UNITY} t_coef_mode;

    typedef struct packed {
        logic [DATA_W-1:0] filtered;
        logic              saturated;
        logic              div_error;
    } t_filt_out;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [DATA_W-1:0]  value;
        logic               restart;
        logic               has_exp;
        t_filt_out          exp_out;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata;
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [DATA_W-1:0]     i_cfg_data;

    t_coef                 ff_coef [NUM_BANK];
    t_coef                 fb_coef [NUM_BANK];
    logic signed [15:0]    past_samples [NTAPS-1];
    logic signed [47:0]    fb_states [NTAPS-1];

    t_filt_out             filt_expected [$];
    t_row                  script [$];
    int                    mismatches   = 0;
    int                    results_seen = 0;
    int                    hold_left    = 0;
    int                    stall_left   = 0;
    bit                    calm         = 1'b0;
    bit                    offering     = 1'b0;
    bit                    cfg_open     = 1'b0;

    iir_filter_direct_form_top #(
        .TAPS(NTAPS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_filt_out filter_step(logic signed [15:0] x, logic restart);
        longint    acc;
        longint    y;
        t_filt_out r;
        r = '0;
        if (restart) begin
            for (int i = 0; i < NTAPS - 1; i++) begin
                past_samples[i] = '0;
                fb_states[i]    = '0;
            end
        end
        acc = longint'(ff_coef[0]) * longint'(x);
        for (int i = 1; i < NTAPS; i++)
            acc += longint'(ff_coef[i]) * longint'(past_samples[i-1]);
        acc += longint'(fb_states[0]);
        if (fb_coef[0] == 0) begin
            y           = 0;
            r.div_error = 1'b1;
        end else begin
            y = acc / longint'(fb_coef[0]);
            if (y > 32767) begin
                y           = 32767;
                r.saturated = 1'b1;
            end else if (y < -32768) begin
                y           = -32768;
                r.saturated = 1'b1;
            end
        end
        for (int i = 0; i < NTAPS - 1; i++)
            fb_states[i] = 48'(((i < NTAPS - 2) ? longint'(fb_states[i+1]) : 64'sd0)
                               - longint'(fb_coef[i+1]) * y);
        for (int i = NTAPS - 2; i > 0; i--)
            past_samples[i] = past_samples[i-1];
        past_samples[0] = x;
        r.filtered = y[15:0];
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        if ($urandom_range(0, 7) == 0)
            return pick_edge();
        return DATA_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] coef_for(t_coef_mode mode, int r);
        case (mode)
            MODE_WILD:  return DATA_W'($urandom);
            MODE_EDGE:  return pick_edge();
            MODE_UNITY: return (r == REG_FF0 || r == REG_FB0) ? COEF_ONE : '0;
            default: begin
                if (r == REG_FB0)
                    return (mode == MODE_NODIV) ? '0
                         : DATA_W'(4096 + int'($urandom_range(0, 2048)) - 1024);
                if (r > REG_FB0)
                    return DATA_W'(int'($urandom_range(0, 1200)) - 600);
                return DATA_W'(int'($urandom_range(0, 4096)) - 2048);
            end
        endcase
    endfunction

    function automatic t_row row_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        t_row r;
        r = '{ROW_CFG, idx, value, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row row_chk(logic [DATA_W-1:0] x, logic restart,
                                     logic [DATA_W-1:0] y, logic sat, logic derr);
        t_row r;
        r = '{ROW_SAMPLE, '0, x, restart, 1'b1, '{y, sat, derr}};
        return r;
    endfunction

    function automatic t_row row_pred(logic [DATA_W-1:0] x, logic restart);
        t_row r;
        r = '{ROW_SAMPLE, '0, x, restart, 1'b0, '0};
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("tb: mismatch on %s at result %0d: got %0d, expected %0d",
                     what, results_seen, got, want);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < CFG_NUM_REGS) begin
            if (idx < REG_FB_BASE)
                ff_coef[idx] = value;
            else
                fb_coef[idx - REG_FB_BASE] = value;
        end
    endtask

    task automatic send_sample(logic [DATA_W-1:0] x, logic restart,
                               logic has_exp, t_filt_out exp_out);
        t_filt_out predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x;
        s_axis_tuser  <= restart;
        offering       = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = filter_step(x, restart);
        filt_expected.push_back(has_exp ? exp_out : predicted);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            offering       = 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Hold until every result is back and the filter has finished its state update.
    task automatic wait_idle();
        if (offering) begin
            s_axis_tvalid <= 1'b0;
            offering       = 1'b0;
        end
        do @(posedge i_clk); while (filt_expected.size() != 0 || !s_axis_tready);
    endtask

    // Output side: check each transaction, then decide ready for the next cycle.
    always @(posedge i_clk) begin
        t_filt_out want;
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            results_seen++;
            if (filt_expected.size() == 0) begin
                report_mismatch("unexpected result", int'($signed(m_axis_tdata)), 0);
            end else begin
                want = filt_expected.pop_front();
                if (m_axis_tdata !== want.filtered)
                    report_mismatch("filtered", int'($signed(m_axis_tdata)),
                                    int'($signed(want.filtered)));
                if (m_axis_tuser[0] !== want.saturated)
                    report_mismatch("saturated", int'(m_axis_tuser[0]), int'(want.saturated));
                if (m_axis_tuser[1] !== want.div_error)
                    report_mismatch("divide_error", int'(m_axis_tuser[1]),
                                    int'(want.div_error));
            end
            if (results_seen == HOLD_AT)
                hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 5);
        end
    end

    initial begin
        t_coef_mode mode;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        for (int i = 0; i < NUM_BANK; i++) begin
            ff_coef[i] = (i == 0) ? COEF_ONE : '0;
            fb_coef[i] = (i == 0) ? COEF_ONE : '0;
        end
        for (int i = 0; i < NTAPS - 1; i++) begin
            past_samples[i] = '0;
            fb_states[i]    = '0;
        end

        // unity filter out of reset passes samples through
        script.push_back(row_chk(16'h7FFF, 1'b0, 16'h7FFF, 1'b0, 1'b0));
        script.push_back(row_chk(16'h8000, 1'b0, 16'h8000, 1'b0, 1'b0));
        script.push_back(row_chk(16'h0000, 1'b0, 16'h0000, 1'b0, 1'b0));
        script.push_back(row_chk(16'hFFFF, 1'b0, 16'hFFFF, 1'b0, 1'b0));
        script.push_back(row_chk(16'h0001, 1'b1, 16'h0001, 1'b0, 1'b0));
        // zero divisor
        script.push_back(row_cfg(REG_FB0, 16'h0000));
        script.push_back(row_chk(16'h3039, 1'b0, 16'h0000, 1'b0, 1'b1));
        script.push_back(row_chk(16'h8000, 1'b1, 16'h0000, 1'b0, 1'b1));
        // tiny divisor clips both ways
        script.push_back(row_cfg(REG_FB0, 16'h0001));
        script.push_back(row_chk(16'h7FFF, 1'b1, Y_MAX, 1'b1, 1'b0));
        script.push_back(row_chk(16'h8000, 1'b1, Y_MIN, 1'b1, 1'b0));
        script.push_back(row_pred(16'h0000, 1'b0));
        // truncation toward zero on a negative quotient
        script.push_back(row_cfg(REG_FF0, 16'h0003));
        script.push_back(row_cfg(REG_FB0, 16'h0002));
        script.push_back(row_pred(16'hFFFF, 1'b1));
        script.push_back(row_pred(16'h0001, 1'b0));
        // extreme coefficients, plus writes to unmapped indexes
        script.push_back(row_cfg(REG_FF0, 16'h7FFF));
        script.push_back(row_cfg(REG_FF1, 16'h8000));
        script.push_back(row_cfg(REG_FF2, 16'h7FFF));
        script.push_back(row_cfg(REG_FF3, 16'h0001));
        script.push_back(row_cfg(REG_FB0, 16'h8000));
        script.push_back(row_cfg(REG_FB1, 16'h7FFF));
        script.push_back(row_cfg(REG_FB2, 16'h8000));
        script.push_back(row_cfg(REG_FB3, 16'hFFFF));
        script.push_back(row_cfg(REG_UNUSED_LO, 16'h0000));
        script.push_back(row_cfg(REG_UNUSED_HI, 16'hFFFF));
        script.push_back(row_pred(16'h7FFF, 1'b0));
        script.push_back(row_pred(16'h8000, 1'b0));
        script.push_back(row_pred(16'h7FFF, 1'b0));
        script.push_back(row_pred(16'h8000, 1'b0));
        script.push_back(row_pred(16'h0000, 1'b0));
        script.push_back(row_pred(16'h1234, 1'b0));
        script.push_back(row_pred(16'h8000, 1'b1));
        script.push_back(row_pred(16'hFFFF, 1'b0));
        // moderate feedback with a live state chain
        script.push_back(row_cfg(REG_FF0, 16'h1000));
        script.push_back(row_cfg(REG_FF1, 16'h1000));
        script.push_back(row_cfg(REG_FF2, 16'h1000));
        script.push_back(row_cfg(REG_FF3, 16'h1000));
        script.push_back(row_cfg(REG_FB0, 16'h1000));
        script.push_back(row_cfg(REG_FB1, 16'h0800));
        script.push_back(row_cfg(REG_FB2, 16'hFC00));
        script.push_back(row_cfg(REG_FB3, 16'h0100));
        script.push_back(row_pred(16'h4000, 1'b1));
        script.push_back(row_pred(16'h4000, 1'b0));
        script.push_back(row_pred(16'hC000, 1'b0));
        script.push_back(row_pred(16'h0000, 1'b0));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) begin
            if (script[n].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    wait_idle();
                    cfg_open = 1'b1;
                end
                write_reg(script[n].idx, script[n].value);
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open     = 1'b0;
                end
                send_sample(script[n].value, script[n].restart,
                            script[n].has_exp, script[n].exp_out);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mode = (phase == NUM_PHASES - 1) ? MODE_UNITY : t_coef_mode'(phase % 4);
            if (phase == NUM_PHASES - 1)
                calm = 1'b1;
            wait_idle();
            for (int r = REG_FF0; r <= REG_FB3; r++)
                write_reg(r[CFG_IDX_W-1:0], coef_for(mode, r));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                          DATA_W'($urandom));
            i_cfg_valid <= 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2)
                    wait_idle();
                send_sample(pick_sample(), $urandom_range(0, 15) == 0, 1'b0, '0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (filt_expected.size() != 0)
            report_mismatch("missing results", 0, filt_expected.size());
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
